// ===== src/tachometer_rpm_meter_top_defines.svh =====
`ifndef TACHOMETER_RPM_METER_TOP_DEFINES_SVH
`define TACHOMETER_RPM_METER_TOP_DEFINES_SVH

// same-cycle implication, checked on every clk edge out of reset
`define TRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/trm_pkg.sv =====
package trm_pkg;

  localparam int TIME_WIDTH  = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int RPM_WIDTH   = 24;
  localparam int PPR_WIDTH   = 8;
  localparam int EDGE_WIDTH  = 8;
  localparam int CONST_WIDTH = 33;
  localparam int NUM_WIDTH   = COUNT_WIDTH + CONST_WIDTH;
  localparam int DEN_WIDTH   = TIME_WIDTH + PPR_WIDTH;
  localparam int SAT_WIDTH   = DEN_WIDTH + RPM_WIDTH;
  localparam int STEP_WIDTH  = $clog2(RPM_WIDTH);

  localparam logic [CONST_WIDTH-1:0] CENTI_RPM_US = 33'd6000000000;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = '1;
  localparam logic [RPM_WIDTH-1:0]   RPM_MAX      = '1;

  localparam logic [1:0] OP_EDGE    = 2'd0;
  localparam logic [1:0] OP_SAMPLE  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_MULTI = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_PPR  = 2'd1;
  localparam logic [1:0] REG_PPM  = 2'd2;

  localparam logic [1:0] RESET_MODE = MODE_EDGE;
  localparam logic [PPR_WIDTH-1:0]  RESET_PPR = 8'd20;
  localparam logic [EDGE_WIDTH-1:0] RESET_PPM = 8'd10;

  typedef struct packed {
    logic [1:0]            op;
    logic [TIME_WIDTH-1:0] time_us;
    logic                  sensor_level;
  } in_item_t;

  typedef struct packed {
    logic [RPM_WIDTH-1:0] rpm_centi;
    logic                 saturated;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic check;
    logic step;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic emit;
    logic dest_held;
    logic over;
  } status_t;

endpackage

// ===== src/trm_ctrl.sv =====
module trm_ctrl
  import trm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  output logic    result_valid,
  input  logic    result_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(RPM_WIDTH - 1);

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [STEP_WIDTH-1:0] step_count;
  logic                  out_free;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.capture = item_valid;
        if (item_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.exec = 1'b1;
        if (status.need_div) state_next = S_MUL;
        else if (status.emit) state_next = S_EMIT;
        else state_next = S_IDLE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.over ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (step_count == LAST_STEP) state_next = S_FIN;
      end
      S_FIN: begin
        if (status.dest_held) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.check) step_count <= '0;
      else if (cmd.step) step_count <= step_count + 1'b1;
      if (cmd.load_out) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

endmodule

// ===== src/trm_datapath.sv =====
module trm_datapath
  import trm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  in_item_t   item,
  input  cmd_t       cmd,
  output status_t    status,
  output out_item_t  result
);

  // configuration
  logic [1:0]            mode;
  logic [PPR_WIDTH-1:0]  ppr;
  logic [EDGE_WIDTH-1:0] ppm;
  logic [PPR_WIDTH-1:0]  ppr_eff;
  logic [EDGE_WIDTH-1:0] ppm_eff;

  // measurement state
  logic                   prev_level;
  logic [TIME_WIDTH-1:0]  last_edge_time;
  logic [EDGE_WIDTH-1:0]  edge_count;
  logic [TIME_WIDTH-1:0]  window_start_time;
  logic [RPM_WIDTH-1:0]   held_rpm;
  logic                   held_sat;
  logic [COUNT_WIDTH-1:0] window_pulses;
  logic [TIME_WIDTH-1:0]  last_sample_time;
  logic                   dest_held;

  logic                   prev_level_next;
  logic [TIME_WIDTH-1:0]  last_edge_time_next;
  logic [EDGE_WIDTH-1:0]  edge_count_next;
  logic [TIME_WIDTH-1:0]  window_start_time_next;
  logic [COUNT_WIDTH-1:0] window_pulses_next;
  logic [TIME_WIDTH-1:0]  last_sample_time_next;
  logic                   dest_held_next;

  // captured item
  logic [1:0]            op;
  logic [TIME_WIDTH-1:0] now;
  logic                  level;

  // decode results
  logic                   need_div;
  logic                   emit;
  logic [COUNT_WIDTH-1:0] ivl;
  logic [TIME_WIDTH-1:0]  dlt;
  logic [RPM_WIDTH-1:0]   q_init;
  logic                   s_init;
  logic [TIME_WIDTH-1:0]  start;
  logic [EDGE_WIDTH-1:0]  ec_inc;

  // divider
  logic [COUNT_WIDTH-1:0] ivl_r;
  logic [TIME_WIDTH-1:0]  dlt_r;
  logic [NUM_WIDTH-1:0]   num;
  logic [DEN_WIDTH-1:0]   den;
  logic [NUM_WIDTH-1:0]   num_prod;
  logic [DEN_WIDTH-1:0]   den_prod;
  logic [DEN_WIDTH-1:0]   rem;
  logic [RPM_WIDTH-1:0]   quo;
  logic                   sat;
  logic                   over;
  logic [DEN_WIDTH:0]     trial;
  logic [DEN_WIDTH:0]     diff;
  logic                   take;

  assign ppr_eff = (ppr == '0) ? PPR_WIDTH'(1) : ppr;
  assign ppm_eff = (ppm < EDGE_WIDTH'(2)) ? EDGE_WIDTH'(2) : ppm;

  always_comb begin
    prev_level_next        = prev_level;
    last_edge_time_next    = last_edge_time;
    edge_count_next        = edge_count;
    window_start_time_next = window_start_time;
    window_pulses_next     = window_pulses;
    last_sample_time_next  = last_sample_time;
    dest_held_next         = 1'b0;
    need_div               = 1'b0;
    emit                   = 1'b0;
    ivl                    = '0;
    dlt                    = '0;
    q_init                 = '0;
    s_init                 = 1'b0;
    start                  = (edge_count == '0) ? now : window_start_time;
    ec_inc                 = edge_count + EDGE_WIDTH'(1);
    unique case (op)
      OP_EDGE: begin
        if (mode == MODE_MULTI) begin
          window_start_time_next = start;
          if (ec_inc >= ppm_eff) begin
            dlt             = now - start;
            edge_count_next = '0;
            if (dlt != '0) begin
              need_div       = 1'b1;
              dest_held_next = 1'b1;
              ivl            = COUNT_WIDTH'(ppm_eff - EDGE_WIDTH'(1));
            end
          end else begin
            edge_count_next = ec_inc;
          end
        end else if (mode == MODE_COUNT) begin
          if (window_pulses != COUNT_MAX) window_pulses_next = window_pulses + 1'b1;
        end
      end
      OP_RESTART: begin
        edge_count_next    = '0;
        window_pulses_next = '0;
      end
      OP_SAMPLE: begin
        emit = 1'b1;
        unique case (mode)
          MODE_EDGE: begin
            if (level && !prev_level) begin
              dlt                 = now - last_edge_time;
              last_edge_time_next = now;
              if (dlt != '0) begin
                need_div = 1'b1;
                ivl      = COUNT_WIDTH'(1);
              end
            end
            prev_level_next = level;
          end
          MODE_MULTI: begin
            q_init = held_rpm;
            s_init = held_sat;
          end
          MODE_COUNT: begin
            dlt = now - last_sample_time;
            if (dlt != '0) begin
              need_div              = 1'b1;
              ivl                   = window_pulses;
              window_pulses_next    = '0;
              last_sample_time_next = now;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign num_prod = NUM_WIDTH'(ivl_r) * NUM_WIDTH'(CENTI_RPM_US);
  assign den_prod = DEN_WIDTH'(dlt_r) * DEN_WIDTH'(ppr_eff);
  assign over     = SAT_WIDTH'(num) >= {den, {RPM_WIDTH{1'b0}}};
  assign trial    = {rem, quo[RPM_WIDTH-1]};
  assign diff     = trial - {1'b0, den};
  assign take     = trial >= {1'b0, den};

  assign status.need_div  = need_div;
  assign status.emit      = emit;
  assign status.dest_held = dest_held;
  assign status.over      = over;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= RESET_MODE;
      ppr               <= RESET_PPR;
      ppm               <= RESET_PPM;
      prev_level        <= 1'b0;
      last_edge_time    <= '0;
      edge_count        <= '0;
      window_start_time <= '0;
      held_rpm          <= '0;
      held_sat          <= 1'b0;
      window_pulses     <= '0;
      last_sample_time  <= '0;
      dest_held         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MODE: mode <= cfg_data[1:0];
          REG_PPR:  ppr  <= cfg_data;
          REG_PPM:  ppm  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        prev_level        <= prev_level_next;
        last_edge_time    <= last_edge_time_next;
        edge_count        <= edge_count_next;
        window_start_time <= window_start_time_next;
        window_pulses     <= window_pulses_next;
        last_sample_time  <= last_sample_time_next;
        dest_held         <= dest_held_next;
      end
      if (cmd.finish) begin
        held_rpm <= quo;
        held_sat <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= item.op;
      now   <= item.time_us;
      level <= item.sensor_level;
    end
    if (cmd.exec) begin
      ivl_r <= ivl;
      dlt_r <= dlt;
      quo   <= q_init;
      sat   <= s_init;
    end
    if (cmd.mul) begin
      num <= num_prod;
      den <= den_prod;
    end
    if (cmd.check) begin
      if (over) begin
        quo <= RPM_MAX;
        sat <= 1'b1;
      end else begin
        rem <= DEN_WIDTH'(num >> RPM_WIDTH);
        quo <= num[RPM_WIDTH-1:0];
        sat <= 1'b0;
      end
    end
    if (cmd.step) begin
      rem <= take ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
      quo <= {quo[RPM_WIDTH-2:0], take};
    end
    if (cmd.load_out) begin
      result.rpm_centi <= quo;
      result.saturated <= sat;
    end
  end

endmodule

// ===== src/tachometer_rpm_meter_top.sv =====
// Tachometer: turns encoder edge and sample-request beats into speed in hundredths of rpm,
// truncated and saturating, one result beat per sample request. The block works on one
// beat at a time. Edges and restarts only pass decode; a sample with no division goes
// from decode to the output load. A sample that needs a speed computation goes through
// decode, a multiply step for the two multipliers (intervals times 6e9, elapsed time times
// pulses per revolution), an overflow compare, the radix-2 restoring divider (one quotient
// bit per cycle), a finish step and the output load. An edge that closes a mode 1 block
// writes its speed to the held register in the finish step, with no output load. A speed
// past full scale skips the divider. A result waits in the output register while the
// next beat is taken; the block holds only if a second result is ready before the first has
// left. Configuration writes are always ready and must be made while no beat is in progress.
`include "tachometer_rpm_meter_top_defines.svh"

module tachometer_rpm_meter_top
  import trm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  in_item_t   item,
  output logic       result_valid,
  input  logic       result_stall,
  output out_item_t  result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  trm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  trm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  `TRM_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall,
                   "block took a beat and did not go busy")
  `TRM_ASSERT_NOW(a_sat_is_max, result_valid && result.saturated, result.rpm_centi == RPM_MAX,
                  "saturated result not at full scale")
  `TRM_ASSERT_NOW(a_result_from_load, $rose(result_valid), $past(cmd.load_out),
                  "result beat raised without an output load")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import trm_pkg::*;

  localparam logic [1:0] OP_NONE   = 2'd3;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int SETTLE_CYCLES     = 40;
  localparam int BEATS_PER_SETTING = 50;
  localparam longint RUN_LIMIT_NS  = 8_000_000;

  typedef struct {
    bit         is_cfg;
    in_item_t   beat;
    logic [1:0] mode;
    logic [7:0] ppr;
    logic [7:0] ppm;
    bit         typed;
    out_item_t  want;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  in_item_t   item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  out_item_t  result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // typed expectation travelling alongside the beat on the wire
  logic      pin_typed = 1'b0;
  out_item_t pin_want = '0;

  int send_idle = 7;
  int recv_idle = 63;

  logic [1:0] cfg_mode = RESET_MODE;
  logic [7:0] cfg_ppr  = RESET_PPR;
  logic [7:0] cfg_ppm  = RESET_PPM;

  logic                   sense_prev = 1'b0;
  logic [TIME_WIDTH-1:0]  edge_stamp = '0;
  logic [7:0]             block_edges = '0;
  logic [TIME_WIDTH-1:0]  block_start = '0;
  out_item_t              held_speed = '0;
  logic [COUNT_WIDTH-1:0] window_count = '0;
  logic [TIME_WIDTH-1:0]  sample_stamp = '0;

  out_item_t speeds_due [$];

  logic [TIME_WIDTH-1:0] clock_us = '0;
  logic drive_level = 1'b0;
  int mismatches = 0;
  int beats_taken = 0;
  int speeds_seen = 0;
  int sat_seen = 0;
  int settings_done = 0;

  tachometer_rpm_meter_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle);
  end

  function automatic out_item_t rpm_from(logic [COUNT_WIDTH-1:0] intervals,
                                         logic [TIME_WIDTH-1:0] elapsed,
                                         logic [7:0] per_rev);
    out_item_t r;
    logic [63:0] quot;
    quot = (64'(intervals) * 64'(CENTI_RPM_US)) / (64'(elapsed) * 64'(per_rev));
    r.saturated = quot > 64'(RPM_MAX);
    r.rpm_centi = r.saturated ? RPM_MAX : quot[RPM_WIDTH-1:0];
    return r;
  endfunction

  // advances the speed state by one beat, returns 1 when a result is due
  function automatic bit speed_of_beat(in_item_t b, output out_item_t r);
    logic [7:0] ppr_eff;
    logic [7:0] ppm_eff;
    logic [TIME_WIDTH-1:0] delta;
    r = '0;
    ppr_eff = (cfg_ppr == 8'd0) ? 8'd1 : cfg_ppr;
    ppm_eff = (cfg_ppm < 8'd2) ? 8'd2 : cfg_ppm;
    case (b.op)
      OP_EDGE: begin
        if (cfg_mode == MODE_MULTI) begin
          if (block_edges == 8'd0) block_start = b.time_us;
          block_edges = block_edges + 8'd1;
          if (block_edges >= ppm_eff) begin
            delta = b.time_us - block_start;
            if (delta != '0) held_speed = rpm_from(COUNT_WIDTH'(ppm_eff - 8'd1), delta, ppr_eff);
            block_edges = 8'd0;
          end
        end else if (cfg_mode == MODE_COUNT && window_count != COUNT_MAX) begin
          window_count = window_count + 1'b1;
        end
        return 1'b0;
      end
      OP_RESTART: begin
        block_edges = 8'd0;
        window_count = '0;
        return 1'b0;
      end
      OP_SAMPLE: begin
        case (cfg_mode)
          MODE_EDGE: begin
            if (b.sensor_level && !sense_prev) begin
              delta = b.time_us - edge_stamp;
              if (delta != '0) r = rpm_from(COUNT_WIDTH'(1), delta, ppr_eff);
              edge_stamp = b.time_us;
            end
            sense_prev = b.sensor_level;
          end
          MODE_MULTI: r = held_speed;
          MODE_COUNT: begin
            delta = b.time_us - sample_stamp;
            if (delta != '0) begin
              r = rpm_from(window_count, delta, ppr_eff);
              window_count = '0;
              sample_stamp = b.time_us;
            end
          end
          default: ;
        endcase
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic note_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected rpm_centi %0d saturated %0b, got rpm_centi %0d saturated %0b",
               $time, what, want.rpm_centi, want.saturated, got.rpm_centi, got.saturated);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (speeds_due.size() == 0) begin
          note_mismatch("unexpected result", '0, result);
        end else begin
          want = speeds_due.pop_front();
          speeds_seen++;
          if (want.saturated) sat_seen++;
          if (result.rpm_centi !== want.rpm_centi || result.saturated !== want.saturated)
            note_mismatch("wrong result", want, result);
        end
      end
      if (item_valid && !item_stall) begin
        beats_taken++;
        if (speed_of_beat(item, want)) speeds_due.push_back(pin_typed ? pin_want : want);
      end
    end
  end

  function automatic in_item_t beat_of(logic [1:0] op, logic [TIME_WIDTH-1:0] t, logic lvl);
    in_item_t b;
    b.op = op;
    b.time_us = t;
    b.sensor_level = lvl;
    return b;
  endfunction

  function automatic plan_row_t beat_row(logic [1:0] op, logic [TIME_WIDTH-1:0] t, logic lvl);
    plan_row_t row;
    row = '{default: '0};
    row.beat = beat_of(op, t, lvl);
    return row;
  endfunction

  function automatic plan_row_t known_row(logic [1:0] op, logic [TIME_WIDTH-1:0] t, logic lvl,
                                          logic [RPM_WIDTH-1:0] rpm, logic sat);
    plan_row_t row;
    row = beat_row(op, t, lvl);
    row.typed = 1'b1;
    row.want.rpm_centi = rpm;
    row.want.saturated = sat;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [1:0] m, logic [7:0] p, logic [7:0] q);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.mode = m;
    row.ppr = p;
    row.ppm = q;
    return row;
  endfunction

  function automatic in_item_t make_beat();
    in_item_t b;
    int unsigned pick;
    pick = $urandom_range(99);
    case ($urandom_range(19))
      0: ;
      1: clock_us = clock_us + $urandom;
      2: clock_us = clock_us + $urandom_range(1, 3);
      default: clock_us = clock_us + $urandom_range(50, 20000);
    endcase
    b = beat_of(OP_SAMPLE, clock_us, 1'($urandom_range(1)));
    if (pick < 8) begin
      b.op = 2'($urandom_range(3));
      b.time_us = $urandom;
    end else if (pick < 11) begin
      b.op = OP_RESTART;
    end else begin
      case (cfg_mode)
        MODE_EDGE: begin
          if (pick < 85) drive_level = !drive_level;
          b.sensor_level = drive_level;
        end
        MODE_MULTI: b.op = (pick < 80) ? OP_EDGE : OP_SAMPLE;
        MODE_COUNT: b.op = (pick < 85) ? OP_EDGE : OP_SAMPLE;
        default: b.op = 2'($urandom_range(3));
      endcase
    end
    return b;
  endfunction

  task automatic send_item(in_item_t b, bit typed = 1'b0, out_item_t known = '0);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= b;
    pin_typed <= typed;
    pin_want <= known;
    do @(posedge clk); while (item_stall);
  endtask

  // lets every due result out, then covers a block end still being computed
  task automatic settle();
    item_valid <= 1'b0;
    pin_typed <= 1'b0;
    @(posedge clk);
    while (speeds_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [1:0] m, logic [7:0] p, logic [7:0] q);
    settle();
    write_reg(REG_MODE, {6'd0, m});
    write_reg(REG_PPR, p);
    write_reg(REG_PPM, q);
    cfg_valid <= 1'b0;
    cfg_mode = m;
    cfg_ppr = p;
    cfg_ppm = q;
    settings_done++;
  endtask

  initial begin : stimulus
    plan_row_t plan [$];
    logic [1:0] m;
    logic [7:0] p;
    logic [7:0] q;
    plan = '{
      known_row(OP_SAMPLE, 32'd0, 1'b0, '0, 1'b0),
      known_row(OP_SAMPLE, 32'd0, 1'b1, '0, 1'b0),
      known_row(OP_SAMPLE, 32'd100, 1'b1, '0, 1'b0),
      known_row(OP_SAMPLE, 32'd150, 1'b0, '0, 1'b0),
      known_row(OP_SAMPLE, 32'd1, 1'b1, RPM_MAX, 1'b1),
      beat_row(OP_EDGE, 32'd7, 1'b1),
      beat_row(OP_NONE, 32'hFFFF_FFFF, 1'b1),
      known_row(OP_SAMPLE, 32'd2, 1'b0, '0, 1'b0),
      beat_row(OP_SAMPLE, 32'd0, 1'b1),
      known_row(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0, '0, 1'b0),
      beat_row(OP_SAMPLE, 32'd3_000_000, 1'b1),
      beat_row(OP_RESTART, 32'hFFFF_FFFF, 1'b0),
      cfg_row(MODE_MULTI, 8'd20, 8'd0),
      beat_row(OP_EDGE, 32'd1000, 1'b0),
      beat_row(OP_EDGE, 32'd1000, 1'b1),
      known_row(OP_SAMPLE, 32'd1200, 1'b0, '0, 1'b0),
      beat_row(OP_EDGE, 32'd5000, 1'b0),
      beat_row(OP_EDGE, 32'd5001, 1'b0),
      known_row(OP_SAMPLE, 32'd6000, 1'b1, RPM_MAX, 1'b1),
      cfg_row(MODE_COUNT, 8'd0, 8'd255),
      known_row(OP_SAMPLE, 32'd10, 1'b0, '0, 1'b0),
      beat_row(OP_EDGE, 32'd11, 1'b0),
      beat_row(OP_EDGE, 32'd12, 1'b1),
      beat_row(OP_EDGE, 32'd13, 1'b0),
      known_row(OP_SAMPLE, 32'd10, 1'b1, '0, 1'b0),
      beat_row(OP_SAMPLE, 32'd1_000_010, 1'b0),
      cfg_row(MODE_NONE, 8'd1, 8'd1),
      known_row(OP_SAMPLE, 32'd77, 1'b1, '0, 1'b0),
      beat_row(OP_EDGE, 32'd78, 1'b1)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_config(plan[i].mode, plan[i].ppr, plan[i].ppm);
      else send_item(plan[i].beat, plan[i].typed, plan[i].want);
    end

    clock_us = $urandom;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 7 : (phase == 1) ? 63 : 0;
      recv_idle = (phase == 0) ? 63 : (phase == 1) ? 7 : 0;
      for (int s = 0; s < 5; s++) begin
        if (s < 3) m = 2'((s + phase) % 3);
        else m = ($urandom_range(9) == 0) ? MODE_NONE : 2'($urandom_range(2));
        case ($urandom_range(5))
          0: p = 8'd0;
          1: p = 8'd1;
          2: p = 8'd255;
          default: p = 8'($urandom_range(2, 60));
        endcase
        case ($urandom_range(6))
          0: q = 8'd0;
          1: q = 8'd1;
          2: q = 8'd2;
          3: q = 8'd255;
          default: q = 8'($urandom_range(3, 12));
        endcase
        set_config(m, p, q);
        repeat (BEATS_PER_SETTING) send_item(make_beat());
      end
    end

    settle();
    $display("covered %0d beats over %0d register settings in all modes, idle mixes and wrap",
             beats_taken, settings_done);
    $display("checked %0d speed results, %0d saturated, %0d mismatches",
             speeds_seen, sat_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d speed results outstanding", speeds_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/trm_pkg.sv
src/trm_ctrl.sv
src/trm_datapath.sv
src/tachometer_rpm_meter_top.sv
bench/tb.sv
